// File: hw/rtl/psadpcm_pkg.sv
// shared types, constants and helper functions of the ps adpcm frame decoder
// no dependencies
package psadpcm_pkg;

  localparam int MAX_CHANNELS_DEF = 2;

  localparam logic [7:0] FRAME_BYTES_RST   = 8'd9;
  localparam logic [1:0] CHANNEL_COUNT_RST = 2'd1;
  localparam logic [7:0] FRAME_BYTES_MIN   = 8'd2;
  localparam logic [7:0] FRAME_BYTES_MAX   = 8'd128;
  localparam logic [3:0] SHIFT_MAX         = 4'd12;
  localparam logic [3:0] SHIFT_FALLBACK    = 4'd9;
  localparam logic [3:0] COEF_SEL_MAX      = 4'd4;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_BYTES   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 1'd1;

  localparam logic signed [19:0] PCM_MAX = 20'sd32767;
  localparam logic signed [19:0] PCM_MIN = -20'sd32768;

  typedef struct packed {
    logic load;
    logic clear;
    logic header;
    logic sample;
    logic high;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_zero;
    logic new_pending;
  } dp_stat_t;

  function automatic logic signed [7:0] coef_a(input logic [2:0] sel);
    logic signed [7:0] c;
    unique case (sel)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [7:0] coef_b(input logic [2:0] sel);
    logic signed [7:0] c;
    unique case (sel)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > PCM_MAX) begin
      r = 16'sh7fff;
    end else if (v < PCM_MIN) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/psadpcm_ctrl.sv
// controller state machine: sequences byte load, stream clear, header and two samples
// depends on psadpcm_pkg
module psadpcm_ctrl
  import psadpcm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOW  = 2'd1;
  localparam logic [1:0] ST_HIGH = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_LOW;
        end
      end
      ST_LOW: begin
        priority if (stat.new_pending) begin
          cmd.clear = 1'b1;
        end else if (stat.pos_zero) begin
          cmd.header = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          if (out_free) begin
            cmd.sample = 1'b1;
            state_nxt  = ST_HIGH;
          end
        end
      end
      ST_HIGH: begin
        if (out_free) begin
          cmd.sample = 1'b1;
          cmd.high   = 1'b1;
          in_tready  = 1'b1;
          state_nxt  = in_tvalid ? ST_LOW : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    cmd.load = in_tvalid && in_tready;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.sample) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/psadpcm_dp.sv
// datapath: config registers, frame state, channel histories, predictor and output register
// depends on psadpcm_pkg
module psadpcm_dp
  import psadpcm_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [7:0]            in_byte,
  input  logic                  in_new,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic [15:0]           out_sample,
  output logic                  out_chan,
  output logic                  out_last
);

  logic [7:0]        byte_r;
  logic              new_r;
  logic [7:0]        fb_r;
  logic [1:0]        cc_r;
  logic [2:0]        coef_r;
  logic [3:0]        shift_r;
  logic [6:0]        pos_r;
  logic              chan_r;
  logic signed [15:0] prev_r [2];
  logic signed [15:0] pp_r   [2];
  logic [15:0]       out_sample_r;
  logic              out_chan_r;
  logic              out_last_r;

  logic [3:0]         nib;
  logic signed [15:0] scaled;
  logic signed [23:0] prod_a, prod_b;
  logic signed [24:0] pred_sum;
  logic signed [18:0] pred_sh;
  logic signed [19:0] total;
  logic signed [15:0] sample_nxt;
  logic [7:0]         fb_eff;
  logic [7:0]         pos_inc;
  logic               frame_end;
  logic               two_ch;

  assign stat.pos_zero    = (pos_r == 7'd0);
  assign stat.new_pending = new_r;

  assign nib      = cmd.high ? byte_r[7:4] : byte_r[3:0];
  assign scaled   = $signed({nib, 12'h000}) >>> shift_r;
  assign prod_a   = coef_a(coef_r) * prev_r[chan_r];
  assign prod_b   = coef_b(coef_r) * pp_r[chan_r];
  assign pred_sum = 25'(prod_a) + 25'(prod_b);
  assign pred_sh  = 19'(pred_sum >>> 6);
  assign total    = 20'(pred_sh) + 20'(scaled);
  assign sample_nxt = clamp16(total);

  always_comb begin
    if (fb_r < FRAME_BYTES_MIN) begin
      fb_eff = FRAME_BYTES_MIN;
    end else if (fb_r > FRAME_BYTES_MAX) begin
      fb_eff = FRAME_BYTES_MAX;
    end else begin
      fb_eff = fb_r;
    end
  end

  assign pos_inc   = {1'b0, pos_r} + 8'd1;
  assign frame_end = (pos_inc >= fb_eff);
  assign two_ch    = (MAX_CHANNELS >= 2) && (cc_r >= 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= FRAME_BYTES_RST;
      cc_r <= CHANNEL_COUNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_FRAME_BYTES:   fb_r <= cfg_wdata[7:0];
        REG_CHANNEL_COUNT: cc_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_r   <= 1'b0;
      coef_r  <= '0;
      shift_r <= '0;
      pos_r   <= '0;
      chan_r  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        prev_r[i] <= '0;
        pp_r[i]   <= '0;
      end
    end else begin
      if (cmd.load) begin
        new_r <= in_new;
      end
      priority if (cmd.clear) begin
        new_r   <= 1'b0;
        coef_r  <= '0;
        shift_r <= '0;
        pos_r   <= '0;
        chan_r  <= 1'b0;
        for (int i = 0; i < 2; i++) begin
          prev_r[i] <= '0;
          pp_r[i]   <= '0;
        end
      end else if (cmd.header) begin
        coef_r  <= (byte_r[7:4] > COEF_SEL_MAX) ? 3'd0 : byte_r[6:4];
        shift_r <= (byte_r[3:0] > SHIFT_MAX) ? SHIFT_FALLBACK : byte_r[3:0];
        pos_r   <= 7'd1;
      end else begin
        if (cmd.sample) begin
          prev_r[chan_r] <= sample_nxt;
          pp_r[chan_r]   <= prev_r[chan_r];
          if (cmd.high) begin
            if (frame_end) begin
              pos_r  <= '0;
              chan_r <= two_ch ? !chan_r : 1'b0;
            end else begin
              pos_r  <= pos_inc[6:0];
            end
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_byte;
    end
    if (cmd.sample) begin
      out_sample_r <= sample_nxt;
      out_chan_r   <= chan_r;
      out_last_r   <= cmd.high;
    end
  end

  assign out_sample = out_sample_r;
  assign out_chan   = out_chan_r;
  assign out_last   = out_last_r;

endmodule

// File: hw/rtl/ps_adpcm_frame_decoder_top.sv
// ps adpcm frame decoder: a data byte gives two samples, one per pass through the
// predictor multiply-add and clamp, each held until the output is free; a header
// byte is loaded then decoded, and a byte flagged new_stream adds a history clear step
// the low sample is registered on out_tdata after the byte is loaded, then the high one
// the next byte is taken in the cycle the second sample is produced
// rst_n synchronous: histories and frame state zero, frame_bytes 9, channel_count 1
module ps_adpcm_frame_decoder_top
  import psadpcm_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // data_byte
  input  logic                  in_tuser,   // new_stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // pcm_sample
  output logic                  out_tuser,  // sample_channel
  output logic                  out_tlast   // last_of_byte
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  psadpcm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  psadpcm_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_byte    (in_tdata),
    .in_new     (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_sample (out_tdata),
    .out_chan   (out_tuser),
    .out_last   (out_tlast)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.header, cmd.sample}))
    else $error("more than one datapath command at once");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sample |-> (!out_tvalid || out_tready))
    else $error("sample written over an untaken result");

  a_high_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sample && cmd.high) |=> (out_tvalid && out_tlast))
    else $error("high nibble sample not flagged last");

  a_new_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (stat.new_pending == $past(in_tuser)))
    else $error("new_stream flag not captured");

endmodule

// File: dv/ps_adpcm_frame_decoder_checker.sv
// checker for the ps adpcm frame decoder: snoops the config port and both streams,
// predicts every decoded sample and compares it with what leaves the block
// depends on psadpcm_pkg for the config port widths, register indexes and limits
module ps_adpcm_frame_decoder_checker
  import psadpcm_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // data_byte
  input  logic                  in_tuser,   // new_stream
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [15:0]           out_tdata,  // pcm_sample
  input  logic                  out_tuser,  // sample_channel
  input  logic                  out_tlast,  // last_of_byte
  output int                    fail_count,
  output int                    backlog,
  output int                    samples_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] pcm;
    logic               chan;
    logic               hi;
  } pcm_result_t;

  pcm_result_t pending_pcm_q[$];

  logic [7:0] frame_len_reg;
  logic [1:0] chan_cnt_reg;
  int         hist_1[2];
  int         hist_2[2];
  logic [2:0] coef_sel;
  logic [3:0] shift_amt;
  int         frame_pos;
  logic       cur_chan;

  initial begin
    fail_count      = 0;
    backlog         = 0;
    samples_checked = 0;
  end

  function automatic int gain_a(input logic [2:0] sel);
    case (sel)
      3'd1:    return 60;
      3'd2:    return 115;
      3'd3:    return 98;
      3'd4:    return 122;
      default: return 0;
    endcase
  endfunction

  function automatic int gain_b(input logic [2:0] sel);
    case (sel)
      3'd2:    return -52;
      3'd3:    return -55;
      3'd4:    return -60;
      default: return 0;
    endcase
  endfunction

  // one nibble through shift, prediction and saturation; updates the channel history
  function automatic logic signed [15:0] decode_nibble(input logic [3:0] code, input logic ch);
    int step;
    int pred;
    int sum;
    step = $signed({code, 12'h000});
    step = step >>> shift_amt;
    pred = gain_a(coef_sel) * hist_1[ch] + gain_b(coef_sel) * hist_2[ch];
    sum  = step + (pred >>> 6);
    if (sum > 32767) begin
      sum = 32767;
    end else if (sum < -32768) begin
      sum = -32768;
    end
    hist_2[ch] = hist_1[ch];
    hist_1[ch] = sum;
    return sum[15:0];
  endfunction

  function automatic void clear_stream();
    for (int i = 0; i < 2; i++) begin
      hist_1[i] = 0;
      hist_2[i] = 0;
    end
    coef_sel  = '0;
    shift_amt = '0;
    frame_pos = 0;
    cur_chan  = 1'b0;
  endfunction

  always @(posedge clk) begin : predict_and_compare
    int          fb_eff;
    int          nch;
    logic        ch;
    logic [15:0] lo_pcm;
    logic [15:0] hi_pcm;
    pcm_result_t want;
    pcm_result_t got;
    if (!rst_n) begin
      frame_len_reg = FRAME_BYTES_RST;
      chan_cnt_reg  = CHANNEL_COUNT_RST;
      clear_stream();
      pending_pcm_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_FRAME_BYTES:   frame_len_reg = cfg_wdata;
          REG_CHANNEL_COUNT: chan_cnt_reg  = cfg_wdata[1:0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        if (in_tuser) begin
          clear_stream();
        end
        fb_eff = frame_len_reg;
        if (fb_eff < FRAME_BYTES_MIN) fb_eff = FRAME_BYTES_MIN;
        if (fb_eff > FRAME_BYTES_MAX) fb_eff = FRAME_BYTES_MAX;
        nch = chan_cnt_reg;
        if (nch < 1) nch = 1;
        if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
        if (nch > 2) nch = 2;

        if (frame_pos == 0) begin
          coef_sel  = (in_tdata[7:4] > COEF_SEL_MAX) ? 3'd0 : in_tdata[6:4];
          shift_amt = (in_tdata[3:0] > SHIFT_MAX) ? SHIFT_FALLBACK : in_tdata[3:0];
          frame_pos = 1;
        end else begin
          ch     = cur_chan;
          lo_pcm = decode_nibble(in_tdata[3:0], ch);
          hi_pcm = decode_nibble(in_tdata[7:4], ch);
          want   = '{lo_pcm, ch, 1'b0};
          pending_pcm_q.insert(pending_pcm_q.size(), want);
          want   = '{hi_pcm, ch, 1'b1};
          pending_pcm_q.insert(pending_pcm_q.size(), want);
          if (frame_pos + 1 >= fb_eff) begin
            frame_pos = 0;
            cur_chan  = (nch == 2) ? ~ch : 1'b0;
          end else begin
            frame_pos = (frame_pos + 1) & 'h7f;
          end
        end
      end

      if (out_tvalid && out_tready) begin
        got = '{out_tdata, out_tuser, out_tlast};
        if (pending_pcm_q.size() == 0) begin
          $display("%0t: unexpected sample exp none, got pcm=%0d ch=%0d last=%0d", $time,
                   $signed(got.pcm), got.chan, got.hi);
          fail_count++;
        end else begin
          want = pending_pcm_q.pop_front();
          samples_checked++;
          if (got.pcm !== want.pcm || got.chan !== want.chan || got.hi !== want.hi) begin
            $display("%0t: sample mismatch exp pcm=%0d ch=%0d last=%0d, %s",
                     $time, $signed(want.pcm), want.chan, want.hi,
                     $sformatf("got pcm=%0d ch=%0d last=%0d",
                               $signed(got.pcm), got.chan, got.hi));
            fail_count++;
          end
        end
      end
    end
    backlog = pending_pcm_q.size();
  end

endmodule

// File: dv/tb_ps_adpcm_frame_decoder_top.sv
// testbench top for the ps adpcm frame decoder: clock, reset, config writes,
// byte stimulus with random gaps and output stalls, verdict
// depends on psadpcm_pkg, ps_adpcm_frame_decoder_top and ps_adpcm_frame_decoder_checker
module tb_ps_adpcm_frame_decoder_top;
  import psadpcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;
  localparam int IDLE_GAP    = 8;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  int   fail_count;
  int   backlog;
  int   samples_checked;

  bit   calm          = 1'b0;
  logic in_fire_q     = 1'b0;
  int   stuck_cycles  = 0;
  int   bytes_sent    = 0;
  int   headers_sent  = 0;
  int   restarts_sent = 0;
  int   frame_cursor  = 0;
  int   frame_len_now = 9;
  int   settings_used = 1;

  ps_adpcm_frame_decoder_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  ps_adpcm_frame_decoder_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .backlog         (backlog),
    .samples_checked (samples_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    in_fire_q <= in_tvalid && in_tready;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d samples outstanding", $time,
               stuck_cycles, backlog);
      $display("FAIL");
      $finish;
    end
  end

  // one request on the input stream; returns at the falling edge after acceptance
  task automatic push_byte(input logic [7:0] b, input logic ns);
    while (!calm && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= ns;
    @(negedge clk);
    while (!in_fire_q) @(negedge clk);
    bytes_sent++;
    if (ns) begin
      restarts_sent++;
      frame_cursor = 0;
    end
    if (frame_cursor == 0) headers_sent++;
    frame_cursor++;
    if (frame_cursor >= frame_len_now) frame_cursor = 0;
  endtask

  // register writes only once the block has drained
  task automatic write_setting(input logic [7:0] fb, input logic [7:0] cc);
    in_tvalid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_FRAME_BYTES;
    cfg_wdata <= fb;
    @(negedge clk);
    cfg_addr  <= REG_CHANNEL_COUNT;
    cfg_wdata <= cc;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    frame_len_now = (fb < FRAME_BYTES_MIN) ? FRAME_BYTES_MIN :
                    (fb > FRAME_BYTES_MAX) ? FRAME_BYTES_MAX : fb;
    settings_used++;
  endtask

  initial begin : stimulus
    logic [7:0] warm [26];
    logic [7:0] fb_list [9];
    logic [7:0] cc_list [9];
    int         n_items;
    int         r;
    logic       ns;
    logic [7:0] b;

    // saturating frame, fallback header, shift 12, restarts as headers
    warm = '{8'h40, 8'h77, 8'h77, 8'h77, 8'h77, 8'h88, 8'h88, 8'h88, 8'h88,
             8'h5D, 8'hFF, 8'h00, 8'h80, 8'h08, 8'h7F, 8'hF7, 8'h12, 8'h34,
             8'h2C, 8'hA5, 8'h5A,
             8'h3F, 8'h96, 8'h69,
             8'h1E, 8'hC3};
    fb_list = '{8'd2, 8'd0, 8'd128, 8'd5, 8'd255, 8'd17, 8'd1, 8'd64, 8'd9};
    cc_list = '{8'd2, 8'd3, 8'hFE, 8'd1, 8'd0, 8'd2, 8'd2, 8'hFD, 8'd2};

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < 26; i++) begin
      push_byte(warm[i], (i == 0) || (i == 21) || (i == 24));
    end

    for (int p = 0; p < 9; p++) begin
      write_setting(fb_list[p], cc_list[p]);
      calm    = (p == 3);
      n_items = (frame_len_now > 64) ? 240 : 60;
      for (int k = 0; k < n_items; k++) begin
        ns = ($urandom_range(99) < 3);
        if (ns || frame_cursor == 0) begin
          if ($urandom_range(99) < 80) begin
            b = {1'b0, 3'($urandom_range(4)), 4'($urandom_range(12))};
          end else begin
            b = 8'($urandom);
          end
        end else begin
          r = $urandom_range(99);
          if (r < 8) begin
            b = 8'h77;
          end else if (r < 16) begin
            b = 8'h88;
          end else begin
            b = 8'($urandom);
          end
        end
        push_byte(b, ns);
      end
    end
    calm      = 1'b0;
    in_tvalid <= 1'b0;

    while (backlog != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    $display("sent %0d bytes (%0d headers, %0d stream restarts) over %0d register settings",
             bytes_sent, headers_sent, restarts_sent, settings_used);
    $display("compared %0d decoded samples, %0d errors", samples_checked, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
